@@ src/rltfw_pkg.sv @@
// ----------------------------------------------------------------------------
// rltfw_pkg
// shared widths, default sizes, action and status codes of the lock table
// ----------------------------------------------------------------------------
`default_nettype none

package rltfw_pkg;

  // fixed transaction field widths
  localparam int ActionW   = 2;
  localparam int KeyW      = 32;
  localparam int ReqFieldW = 8;
  localparam int StatusW   = 3;

  // default sizing
  localparam int DefLockEntries   = 16;
  localparam int DefQueueDepth    = 8;
  localparam int DefRequesterBits = 8;
  localparam int DefCountBits     = 8;

  // actions
  localparam logic [ActionW-1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [ActionW-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ActionW-1:0] ACT_CHECK   = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK         = 3'd0;
  localparam logic [StatusW-1:0] ST_QUEUED     = 3'd1;
  localparam logic [StatusW-1:0] ST_UNKNOWN    = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_OWNER  = 3'd3;
  localparam logic [StatusW-1:0] ST_TABLE_FULL = 3'd4;
  localparam logic [StatusW-1:0] ST_QUEUE_FULL = 3'd5;
  localparam logic [StatusW-1:0] ST_SATURATED  = 3'd6;

endpackage

`default_nettype wire

@@ src/rltfw_if.sv @@
// ----------------------------------------------------------------------------
// rltfw_if
// valid/ready channels for request and result transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface rltfw_in_if;
  import rltfw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [KeyW-1:0]      lock_key;
  logic [ReqFieldW-1:0] requester;
  modport source (output valid, action, lock_key, requester, input ready);
  modport sink   (input valid, action, lock_key, requester, output ready);
endinterface

interface rltfw_out_if;
  import rltfw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic                 entry_freed;
  logic                 handoff_valid;
  logic [ReqFieldW-1:0] handoff_requester;
  modport source (output valid, status, entry_freed, handoff_valid, handoff_requester,
                  input ready);
  modport sink   (input valid, status, entry_freed, handoff_valid, handoff_requester,
                  output ready);
endinterface

`default_nettype wire

@@ src/rltfw_cam.sv @@
// ----------------------------------------------------------------------------
// rltfw_cam
// key store with valid bits, parallel match and lowest free entry search
// ----------------------------------------------------------------------------
`default_nettype none

module rltfw_cam #(
  parameter int LOCK_ENTRIES = rltfw_pkg::DefLockEntries,
  localparam int IdxW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [rltfw_pkg::KeyW-1:0] look_key,
  input  wire logic                      set_en,
  input  wire logic [IdxW-1:0]           set_idx,
  input  wire logic [rltfw_pkg::KeyW-1:0] set_key,
  input  wire logic                      clr_en,
  input  wire logic [IdxW-1:0]           clr_idx,
  output logic                           hit,
  output logic [IdxW-1:0]                hit_idx,
  output logic                           free_ok,
  output logic [IdxW-1:0]                free_idx
);
  import rltfw_pkg::*;

  logic            valid_r [LOCK_ENTRIES];
  logic [KeyW-1:0] key_r   [LOCK_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOCK_ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      if (set_en) valid_r[set_idx] <= 1'b1;
      if (clr_en) valid_r[clr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (set_en) key_r[set_idx] <= set_key;
  end

  // lowest index wins on both searches
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == look_key) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/recursive_lock_table_fifo_waiters_core.sv @@
// ----------------------------------------------------------------------------
// recursive_lock_table_fifo_waiters_core
// recursive lock manager with per-lock fifo of waiting requesters
// ----------------------------------------------------------------------------
// Each request transaction (acquire, release or check of one lock key by one
// requester) gives exactly one result transaction. Keys sit in a small match
// array; owner, recursion count and queue pointers of each lock sit in an
// entry memory, and queued requesters in a waiter memory, both read through
// a register. An accepted request goes through key match and entry read, then
// update and write back; a release that hands the lock to a waiter adds a
// handoff step, because the waiter memory is read after the entry memory has
// supplied the queue head. One request is in flight at a time, so a new
// request is taken only once the last one has finished; a finished result
// waits in the output register while the next request is accepted, and the
// update stage holds while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module recursive_lock_table_fifo_waiters_core #(
  parameter int LOCK_ENTRIES   = rltfw_pkg::DefLockEntries,
  parameter int QUEUE_DEPTH    = rltfw_pkg::DefQueueDepth,
  parameter int REQUESTER_BITS = rltfw_pkg::DefRequesterBits,
  parameter int COUNT_BITS     = rltfw_pkg::DefCountBits
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rltfw_in_if.sink   in_ch,
  rltfw_out_if.source out_ch
);
  import rltfw_pkg::*;

  localparam int IdxW   = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int QptrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW   = FillW + 1;
  localparam int ReqW   = (REQUESTER_BITS < ReqFieldW) ? REQUESTER_BITS : ReqFieldW;
  localparam int WDepth = LOCK_ENTRIES * QUEUE_DEPTH;
  localparam int WaddrW = (WDepth > 1) ? $clog2(WDepth) : 1;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_HAND = 2'd3;

  typedef struct packed {
    logic [ReqW-1:0]       owner;
    logic [COUNT_BITS-1:0] count;
    logic [QptrW-1:0]      head;
    logic [FillW-1:0]      fill;
  } entry_t;

  // memories
  entry_t          ent_mem [LOCK_ENTRIES];
  logic [ReqW-1:0] wt_mem  [WDepth];

  logic [1:0]         state_r, state_nxt;
  logic [ActionW-1:0] act_r;
  logic [KeyW-1:0]    key_r;
  logic [ReqW-1:0]    req_r;
  logic               hit_r, free_ok_r;
  logic [IdxW-1:0]    idx_r;
  entry_t             ent_rd_r;
  logic [ReqW-1:0]    wt_rd_r;

  // result register
  logic                 out_valid_r;
  logic [StatusW-1:0]   out_status_r, out_status_nxt;
  logic                 out_freed_r, out_freed_nxt;
  logic                 out_hv_r, out_hv_nxt;
  logic [ReqW-1:0]      out_hr_r, out_hr_nxt;

  logic            in_acc, out_free, load_out;
  logic            cam_hit, cam_free_ok;
  logic [IdxW-1:0] cam_hit_idx, cam_free_idx;
  logic            cam_set, cam_clr;

  logic            ent_we;
  entry_t          ent_wd;
  logic            wt_we;
  logic [WaddrW-1:0] wt_waddr, wt_raddr;

  logic [SumW-1:0]       tail_sum;
  logic [QptrW-1:0]      tail_slot, head_next;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  owner_match, queue_full, need_hand;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.entry_freed       = out_freed_r;
  assign out_ch.handoff_valid     = out_hv_r;
  assign out_ch.handoff_requester = ReqFieldW'(out_hr_r);

  rltfw_cam #(
    .LOCK_ENTRIES (LOCK_ENTRIES)
  ) u_cam (
    .clk      (clk),
    .rst_n    (rst_n),
    .look_key (key_r),
    .set_en   (cam_set),
    .set_idx  (idx_r),
    .set_key  (key_r),
    .clr_en   (cam_clr),
    .clr_idx  (idx_r),
    .hit      (cam_hit),
    .hit_idx  (cam_hit_idx),
    .free_ok  (cam_free_ok),
    .free_idx (cam_free_idx)
  );

  // queue arithmetic on the entry read back
  assign tail_sum  = SumW'(ent_rd_r.head) + SumW'(ent_rd_r.fill);
  assign tail_slot = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                     QptrW'(tail_sum - SumW'(QUEUE_DEPTH)) : QptrW'(tail_sum);
  assign head_next = (SumW'(ent_rd_r.head) + SumW'(1) >= SumW'(QUEUE_DEPTH)) ?
                     '0 : QptrW'(ent_rd_r.head + QptrW'(1));
  assign cnt_dec     = (ent_rd_r.count != '0) ? ent_rd_r.count - CountOne : '0;
  assign owner_match = hit_r && (ent_rd_r.owner == req_r);
  assign queue_full  = (ent_rd_r.fill >= FillW'(QUEUE_DEPTH));
  assign need_hand   = (act_r == ACT_RELEASE) && owner_match && (cnt_dec == '0) &&
                       (ent_rd_r.fill != '0);

  assign wt_waddr = WaddrW'(WaddrW'(idx_r) * WaddrW'(QUEUE_DEPTH)) + WaddrW'(tail_slot);
  assign wt_raddr = WaddrW'(WaddrW'(idx_r) * WaddrW'(QUEUE_DEPTH)) + WaddrW'(ent_rd_r.head);

  // decode and write back
  always_comb begin
    state_nxt      = state_r;
    load_out       = 1'b0;
    out_status_nxt = ST_OK;
    out_freed_nxt  = 1'b0;
    out_hv_nxt     = 1'b0;
    out_hr_nxt     = '0;
    cam_set        = 1'b0;
    cam_clr        = 1'b0;
    ent_we         = 1'b0;
    ent_wd         = ent_rd_r;
    wt_we          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (need_hand) begin
          state_nxt = S_HAND;
        end else if (out_free) begin
          state_nxt = S_IDLE;
          load_out  = 1'b1;
          case (act_r)
            ACT_ACQUIRE: begin
              if (!hit_r) begin
                if (free_ok_r) begin
                  // new lock granted to the requester
                  cam_set = 1'b1;
                  ent_we  = 1'b1;
                  ent_wd  = '{owner: req_r, count: CountOne, head: '0, fill: '0};
                end else begin
                  out_status_nxt = ST_TABLE_FULL;
                end
              end else if (owner_match) begin
                if (ent_rd_r.count >= CountMax) begin
                  out_status_nxt = ST_SATURATED;
                end else begin
                  ent_we       = 1'b1;
                  ent_wd.count = ent_rd_r.count + CountOne;
                end
              end else if (queue_full) begin
                out_status_nxt = ST_QUEUE_FULL;
              end else begin
                wt_we          = 1'b1;
                ent_we         = 1'b1;
                ent_wd.fill    = ent_rd_r.fill + FillW'(1);
                out_status_nxt = ST_QUEUED;
              end
            end
            ACT_RELEASE: begin
              if (!hit_r) begin
                out_status_nxt = ST_UNKNOWN;
              end else if (!owner_match) begin
                out_status_nxt = ST_NOT_OWNER;
              end else if (cnt_dec == '0) begin
                // last release with nobody waiting
                cam_clr       = 1'b1;
                out_freed_nxt = 1'b1;
              end else begin
                ent_we       = 1'b1;
                ent_wd.count = cnt_dec;
              end
            end
            ACT_CHECK: begin
              if (!hit_r) out_status_nxt = ST_UNKNOWN;
              else if (!owner_match) out_status_nxt = ST_NOT_OWNER;
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_HAND: begin
        // oldest waiter becomes owner with a count of one
        if (out_free) begin
          state_nxt  = S_IDLE;
          load_out   = 1'b1;
          out_hv_nxt = 1'b1;
          out_hr_nxt = wt_rd_r;
          ent_we     = 1'b1;
          ent_wd     = '{owner: wt_rd_r, count: CountOne, head: head_next,
                         fill: ent_rd_r.fill - FillW'(1)};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // request capture and lookup results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_ch.action;
      key_r <= in_ch.lock_key;
      req_r <= ReqW'(in_ch.requester);
    end
    if (state_r == S_LOOK) begin
      hit_r     <= cam_hit;
      free_ok_r <= cam_free_ok;
      idx_r     <= cam_hit ? cam_hit_idx : cam_free_idx;
      ent_rd_r  <= ent_mem[cam_hit_idx];
    end
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_freed_r  <= out_freed_nxt;
      out_hv_r     <= out_hv_nxt;
      out_hr_r     <= out_hr_nxt;
    end
  end

  // entry memory write port
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[idx_r] <= ent_wd;
  end

  // waiter memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_waddr] <= req_r;
    if (state_r == S_EXEC) wt_rd_r <= wt_mem[wt_raddr];
  end

`ifndef ASSERT_OFF
  a_hand_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hv_r |-> out_status_r == ST_OK && !out_freed_r)
    else $error("handoff result with bad status or freed flag");

  a_hr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hv_r |-> out_hr_r == '0)
    else $error("handoff requester set without handoff");

  a_acc_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_LOOK)
    else $error("accepted request did not enter lookup");

  a_hand_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HAND |-> $past(state_r) == S_EXEC || $past(state_r) == S_HAND)
    else $error("handoff state entered out of sequence");
`endif

endmodule

`default_nettype wire

@@ verif/recursive_lock_table_fifo_waiters_core_test.sv @@
// ----------------------------------------------------------------------------
// recursive_lock_table_fifo_waiters_core_test
// self-checking bench: directed table then random lock traffic, results
// compared against an in-bench model of the lock table and waiter queues
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module recursive_lock_table_fifo_waiters_core_test;
  import rltfw_pkg::*;

  localparam int NumLocks  = DefLockEntries;
  localparam int WaitDepth = DefQueueDepth;
  localparam int CountTop  = (1 << DefCountBits) - 1;
  localparam int NumDirect = 15;

  // action code with no effect
  localparam logic [ActionW-1:0] ActSpare = 2'd3;

  typedef struct packed {
    logic [ActionW-1:0]   action;
    logic [KeyW-1:0]      lock_key;
    logic [ReqFieldW-1:0] requester;
  } lock_req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic                 entry_freed;
    logic                 handoff_valid;
    logic [ReqFieldW-1:0] handoff_requester;
  } lock_rsp_t;

  // directed row: request plus an optional typed-in expected result
  typedef struct {
    lock_req_t req;
    bit        fixed;
    lock_rsp_t rsp;
  } lock_row_t;

  logic clk;
  logic rst_n;

  rltfw_in_if  req_ch ();
  rltfw_out_if rsp_ch ();

  recursive_lock_table_fifo_waiters_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the lock table
  bit                   tbl_valid [NumLocks];
  logic [KeyW-1:0]      tbl_key   [NumLocks];
  logic [ReqFieldW-1:0] tbl_owner [NumLocks];
  int                   tbl_count [NumLocks];
  logic [ReqFieldW-1:0] tbl_wait  [NumLocks][$];

  lock_rsp_t pending_rsp [$];
  int        errors;
  int        rsp_seen;
  int        handoffs;
  int        frees;
  bit        idle_off;

  function automatic lock_rsp_t lock_table_apply(lock_req_t r);
    lock_rsp_t o;
    int e;
    int f;
    o = '0;
    e = -1;
    f = -1;
    for (int i = NumLocks - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == r.lock_key) e = i;
      if (!tbl_valid[i]) f = i;
    end
    case (r.action)
      ACT_ACQUIRE: begin
        if (e < 0) begin
          if (f < 0) begin
            o.status = ST_TABLE_FULL;
          end else begin
            tbl_valid[f] = 1'b1;
            tbl_key[f]   = r.lock_key;
            tbl_owner[f] = r.requester;
            tbl_count[f] = 1;
            tbl_wait[f].delete();
          end
        end else if (tbl_owner[e] == r.requester) begin
          if (tbl_count[e] >= CountTop) o.status = ST_SATURATED;
          else tbl_count[e]++;
        end else if (tbl_wait[e].size() >= WaitDepth) begin
          o.status = ST_QUEUE_FULL;
        end else begin
          tbl_wait[e] = {tbl_wait[e], r.requester};
          o.status = ST_QUEUED;
        end
      end
      ACT_RELEASE: begin
        if (e < 0) begin
          o.status = ST_UNKNOWN;
        end else if (tbl_owner[e] != r.requester) begin
          o.status = ST_NOT_OWNER;
        end else begin
          tbl_count[e]--;
          if (tbl_count[e] == 0) begin
            if (tbl_wait[e].size() == 0) begin
              tbl_valid[e]  = 1'b0;
              o.entry_freed = 1'b1;
            end else begin
              o.handoff_requester = tbl_wait[e][0];
              tbl_wait[e].delete(0);
              o.handoff_valid     = 1'b1;
              tbl_owner[e]        = o.handoff_requester;
              tbl_count[e]        = 1;
            end
          end
        end
      end
      ACT_CHECK: begin
        if (e < 0) o.status = ST_UNKNOWN;
        else if (tbl_owner[e] != r.requester) o.status = ST_NOT_OWNER;
      end
      default: ;
    endcase
    return o;
  endfunction

  // drive one request, wait for acceptance; valid stays high for the next one
  task automatic send_request(lock_req_t r, bit fixed, lock_rsp_t want);
    lock_rsp_t p;
    if (!idle_off && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while (!idle_off && $urandom_range(99) < 25) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= r.action;
    req_ch.lock_key  <= r.lock_key;
    req_ch.requester <= r.requester;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = lock_table_apply(r);
    if (fixed && p != want) begin
      $error("directed row disagrees with model: expected %h, model %h", want, p);
      errors++;
    end
    pending_rsp = {pending_rsp, (fixed ? want : p)};
  endtask

  // result side: random stall, then compare each transaction
  always @(posedge clk) begin
    lock_rsp_t w;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        w = pending_rsp[0];
        pending_rsp.delete(0);
        if (rsp_ch.status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.entry_freed !== w.entry_freed) begin
          $error("entry_freed expected %0d actual %0d", w.entry_freed, rsp_ch.entry_freed);
          errors++;
        end
        if (rsp_ch.handoff_valid !== w.handoff_valid) begin
          $error("handoff_valid expected %0d actual %0d", w.handoff_valid,
                 rsp_ch.handoff_valid);
          errors++;
        end
        if (rsp_ch.handoff_requester !== w.handoff_requester) begin
          $error("handoff_requester expected %0d actual %0d", w.handoff_requester,
                 rsp_ch.handoff_requester);
          errors++;
        end
        frees    += w.entry_freed;
        handoffs += w.handoff_valid;
      end
    end
    rsp_ch.ready <= idle_off || ($urandom_range(99) >= 25);
  end

  function automatic lock_req_t mk(logic [ActionW-1:0] a, logic [KeyW-1:0] k,
                                   logic [ReqFieldW-1:0] q);
    lock_req_t r;
    r.action    = a;
    r.lock_key  = k;
    r.requester = q;
    return r;
  endfunction

  function automatic lock_rsp_t st(logic [StatusW-1:0] s);
    lock_rsp_t o;
    o        = '0;
    o.status = s;
    return o;
  endfunction

  // random request drawn from a small key pool so locks get contended
  function automatic lock_req_t rand_request(int mode);
    lock_req_t r;
    logic [KeyW-1:0] pool [6] = '{32'h0, 32'hFFFF_FFFF, 32'h5555_AAAA,
                                   32'hAAAA_5555, 32'h1234_5678, 32'h8000_0001};
    int a;
    a = $urandom_range(99);
    r.action    = a < 45 ? ACT_ACQUIRE : a < 85 ? ACT_RELEASE : a < 97 ? ACT_CHECK : ActSpare;
    r.lock_key  = mode == 0 ? pool[$urandom_range(5)] : $urandom;
    r.requester = mode == 0 ? 8'($urandom_range(3)) : 8'($urandom);
    // releases mostly by the real owner so queues drain through handoffs
    if (r.action == ACT_RELEASE && mode == 0 && $urandom_range(3) != 0) begin
      for (int i = 0; i < NumLocks; i++)
        if (tbl_valid[i] && tbl_key[i] == r.lock_key) r.requester = tbl_owner[i];
    end
    return r;
  endfunction

  lock_row_t directed [NumDirect];

  initial begin
    lock_rsp_t hv;
    lock_rsp_t fr;
    int guard;
    errors   = 0;
    rsp_seen = 0;
    handoffs = 0;
    frees    = 0;
    idle_off = 1'b0;
    clk      = 1'b0;
    rst_n    = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.action    = '0;
    req_ch.lock_key  = '0;
    req_ch.requester = '0;
    rsp_ch.ready     = 1'b0;
    for (int i = 0; i < NumLocks; i++) tbl_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    fr = '0;
    fr.entry_freed = 1'b1;
    hv = '0;
    hv.handoff_valid     = 1'b1;
    hv.handoff_requester = 8'hFF;
    // unknown lock, creation, recursion, wrong owner, queueing, handoff, free
    directed[0]  = '{mk(ACT_CHECK,   32'hFFFF_FFFF, 8'h00), 1, st(ST_UNKNOWN)};
    directed[1]  = '{mk(ACT_RELEASE, 32'h0,         8'hFF), 1, st(ST_UNKNOWN)};
    directed[2]  = '{mk(ACT_ACQUIRE, 32'hFFFF_FFFF, 8'h00), 1, st(ST_OK)};
    directed[3]  = '{mk(ACT_ACQUIRE, 32'hFFFF_FFFF, 8'h00), 1, st(ST_OK)};
    directed[4]  = '{mk(ACT_CHECK,   32'hFFFF_FFFF, 8'hFF), 1, st(ST_NOT_OWNER)};
    directed[5]  = '{mk(ACT_RELEASE, 32'hFFFF_FFFF, 8'hFF), 1, st(ST_NOT_OWNER)};
    directed[6]  = '{mk(ACT_ACQUIRE, 32'hFFFF_FFFF, 8'hFF), 1, st(ST_QUEUED)};
    directed[7]  = '{mk(ACT_ACQUIRE, 32'hFFFF_FFFF, 8'hFF), 1, st(ST_QUEUED)};
    directed[8]  = '{mk(ACT_CHECK,   32'hFFFF_FFFF, 8'h00), 1, st(ST_OK)};
    directed[9]  = '{mk(ACT_RELEASE, 32'hFFFF_FFFF, 8'h00), 1, st(ST_OK)};
    directed[10] = '{mk(ACT_RELEASE, 32'hFFFF_FFFF, 8'h00), 1, hv};
    // repeat waiter: ff queued twice, so the handoff goes to ff again
    directed[11] = '{mk(ACT_RELEASE, 32'hFFFF_FFFF, 8'hFF), 1, hv};
    directed[12] = '{mk(ACT_RELEASE, 32'hFFFF_FFFF, 8'hFF), 1, fr};
    directed[13] = '{mk(ActSpare,    32'hFFFF_FFFF, 8'hFF), 1, st(ST_OK)};
    directed[14] = '{mk(ACT_CHECK,   32'hFFFF_FFFF, 8'hFF), 1, st(ST_UNKNOWN)};
    foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].rsp);

    // count saturation on one lock
    for (int i = 0; i < CountTop + 1; i++)
      send_request(mk(ACT_ACQUIRE, 32'hC0DE_0000, 8'h5A), 0, '0);
    // queue full on the same lock, with wrapping on drain
    for (int i = 0; i < WaitDepth + 1; i++)
      send_request(mk(ACT_ACQUIRE, 32'hC0DE_0000, 8'(i)), 0, '0);
    for (int i = 0; i < CountTop; i++)
      send_request(mk(ACT_RELEASE, 32'hC0DE_0000, 8'h5A), 0, '0);
    for (int i = 0; i < 3; i++)
      send_request(mk(ACT_RELEASE, 32'hC0DE_0000, 8'(i)), 0, '0);
    for (int i = 0; i < 3; i++)
      send_request(mk(ACT_ACQUIRE, 32'hC0DE_0000, 8'h70 + 8'(i)), 0, '0);
    // fill the table, then overflow it, then release those locks again
    for (int i = 0; i < NumLocks + 1; i++)
      send_request(mk(ACT_ACQUIRE, 32'hF000_0000 + i, 8'h11), 0, '0);
    for (int i = 0; i < NumLocks + 1; i++)
      send_request(mk(ACT_RELEASE, 32'hF000_0000 + i, 8'h11), 0, '0);
    req_ch.valid <= 1'b0;

    // hold the sender until everything outstanding has returned
    while (pending_rsp.size() != 0) @(posedge clk);

    for (int n = 0; n < 375; n++) begin
      idle_off = (n >= 100 && n < 250);
      send_request(rand_request($urandom_range(9) == 0), 0, '0);
    end
    idle_off = 1'b0;
    req_ch.valid <= 1'b0;

    guard = 0;
    while (pending_rsp.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d results never arrived", pending_rsp.size());
      errors++;
    end
    $display("covered %0d results, %0d handoffs, %0d frees; saturation, full queue",
             rsp_seen, handoffs, frees);
    $display("and full table each reached in the directed part");
    if (errors == 0) begin
      $display("recursive_lock_table_fifo_waiters_core_test passed");
    end else begin
      $display("recursive_lock_table_fifo_waiters_core_test failed");
    end
    $finish;
  end

  // run-away guard
  initial begin
    #20ms;
    $display("recursive_lock_table_fifo_waiters_core_test failed");
    $finish;
  end

endmodule

`default_nettype wire
